// ===== sv/assert_macros.svh =====
// Assertion macros shared by the classifier RTL.
// Each macro expects clk and arst_n to be in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define CFK_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked out of reset.
`define CFK_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== sv/cfk_pkg.sv =====
// Shared types, codes and constant tables of the fragment key classifier.
// No dependencies; used by the controller, datapath and top level.
`default_nettype none
package cfk_pkg;

	// Item actions and the last atom slot
	localparam logic [1:0] ACT_KEY   = 2'd0;
	localparam logic [1:0] ACT_CLASS = 2'd1;
	localparam logic [1:0] ACT_ATOM  = 2'd2;
	localparam logic [1:0] SLOT_LAST = 2'd3;

	localparam int BIN_MAX  = 99;
	localparam int KEY_W_HI = 10000;
	localparam int KEY_W_MD = 100;

	// Multiplier sequence: 9 squares, 6 cross terms, 6 triple-product pieces
	localparam int MUL_STEPS = 21;
	localparam int SPLIT_BITS = 24;

	localparam logic [2:0] OP_SQ = 3'd0; // accumulate square into distance sum
	localparam logic [2:0] OP_XP = 3'd1; // load cross term
	localparam logic [2:0] OP_XN = 3'd2; // subtract from cross term
	localparam logic [2:0] OP_TH = 3'd3; // high piece of triple product
	localparam logic [2:0] OP_TL = 3'd4; // low piece of triple product

	typedef struct packed {
		logic [2:0] kind;
		logic [1:0] j;
		logic [1:0] ap;
		logic [1:0] aq;
		logic [1:0] ak;
		logic [1:0] bp;
		logic [1:0] bq;
		logic [1:0] bk;
	} op_t;

	typedef struct packed {
		logic       ready;
		logic       take;
		logic       clr_step;
		logic       mul_issue;
		logic [4:0] mul_step;
		logic       bin_step;
		logic [2:0] bin_bit;
		logic       key_load;
		logic       srch_init;
		logic       srch_upd;
		logic       frag_load;
		logic       out_load;
	} cmd_t;

	typedef struct packed {
		logic in_valid;
		logic classify;
		logic clr_last;
		logic srch_done;
		logic key_empty;
		logic out_full;
	} sts_t;

	function automatic op_t mk_op(input logic [2:0] kind, input logic [1:0] j,
			input logic [1:0] ap, input logic [1:0] aq, input logic [1:0] ak,
			input logic [1:0] bp, input logic [1:0] bq, input logic [1:0] bk);
		op_t o;
		o.kind = kind; o.j = j;
		o.ap = ap; o.aq = aq; o.ak = ak;
		o.bp = bp; o.bq = bq; o.bk = bk;
		return o;
	endfunction

	// u = a1-a0, v = a2-a1, w = a3-a2; c = u x v
	function automatic op_t mul_op(input logic [4:0] step);
		op_t o;
		case (step)
			5'd0:  o = mk_op(OP_SQ, 2'd0, 2'd0, 2'd2, 2'd0, 2'd0, 2'd2, 2'd0);
			5'd1:  o = mk_op(OP_SQ, 2'd0, 2'd0, 2'd2, 2'd1, 2'd0, 2'd2, 2'd1);
			5'd2:  o = mk_op(OP_SQ, 2'd0, 2'd0, 2'd2, 2'd2, 2'd0, 2'd2, 2'd2);
			5'd3:  o = mk_op(OP_SQ, 2'd1, 2'd1, 2'd3, 2'd0, 2'd1, 2'd3, 2'd0);
			5'd4:  o = mk_op(OP_SQ, 2'd1, 2'd1, 2'd3, 2'd1, 2'd1, 2'd3, 2'd1);
			5'd5:  o = mk_op(OP_SQ, 2'd1, 2'd1, 2'd3, 2'd2, 2'd1, 2'd3, 2'd2);
			5'd6:  o = mk_op(OP_SQ, 2'd2, 2'd0, 2'd3, 2'd0, 2'd0, 2'd3, 2'd0);
			5'd7:  o = mk_op(OP_SQ, 2'd2, 2'd0, 2'd3, 2'd1, 2'd0, 2'd3, 2'd1);
			5'd8:  o = mk_op(OP_SQ, 2'd2, 2'd0, 2'd3, 2'd2, 2'd0, 2'd3, 2'd2);
			5'd9:  o = mk_op(OP_XP, 2'd0, 2'd1, 2'd0, 2'd1, 2'd2, 2'd1, 2'd2);
			5'd10: o = mk_op(OP_XN, 2'd0, 2'd1, 2'd0, 2'd2, 2'd2, 2'd1, 2'd1);
			5'd11: o = mk_op(OP_XP, 2'd1, 2'd1, 2'd0, 2'd2, 2'd2, 2'd1, 2'd0);
			5'd12: o = mk_op(OP_XN, 2'd1, 2'd1, 2'd0, 2'd0, 2'd2, 2'd1, 2'd2);
			5'd13: o = mk_op(OP_XP, 2'd2, 2'd1, 2'd0, 2'd0, 2'd2, 2'd1, 2'd1);
			5'd14: o = mk_op(OP_XN, 2'd2, 2'd1, 2'd0, 2'd1, 2'd2, 2'd1, 2'd0);
			5'd15: o = mk_op(OP_TH, 2'd0, 2'd0, 2'd0, 2'd0, 2'd3, 2'd2, 2'd0);
			5'd16: o = mk_op(OP_TL, 2'd0, 2'd0, 2'd0, 2'd0, 2'd3, 2'd2, 2'd0);
			5'd17: o = mk_op(OP_TH, 2'd0, 2'd0, 2'd0, 2'd1, 2'd3, 2'd2, 2'd1);
			5'd18: o = mk_op(OP_TL, 2'd0, 2'd0, 2'd0, 2'd1, 2'd3, 2'd2, 2'd1);
			5'd19: o = mk_op(OP_TH, 2'd0, 2'd0, 2'd0, 2'd2, 2'd3, 2'd2, 2'd2);
			5'd20: o = mk_op(OP_TL, 2'd0, 2'd0, 2'd0, 2'd2, 2'd3, 2'd2, 2'd2);
			default: o = mk_op(OP_SQ, 2'd0, 2'd0, 2'd0, 2'd0, 2'd0, 2'd0, 2'd0);
		endcase
		return o;
	endfunction

	// 9*b*b, the bin threshold before the fraction scaling
	function automatic logic [16:0] sq9(input logic [6:0] b);
		logic [13:0] sq;
		sq = 14'(b) * 14'(b);
		return 17'(sq) * 17'd9;
	endfunction

endpackage
`default_nettype wire

// ===== sv/cfk_in_if.sv =====
// Input channel of the classifier: valid/ready plus one item's fields.
// Depends on nothing but the language.
`default_nettype none
interface cfk_in_if;
	logic               valid;
	logic               ready;
	logic        [1:0]  action;
	logic        [13:0] table_index;
	logic signed [20:0] key_value;
	logic        [9:0]  fragment_id;
	logic        [1:0]  class_value;
	logic        [1:0]  atom_slot;
	logic signed [23:0] coord_x;
	logic signed [23:0] coord_y;
	logic signed [23:0] coord_z;

	modport source(output valid, action, table_index, key_value, fragment_id,
		class_value, atom_slot, coord_x, coord_y, coord_z, input ready);
	modport sink(input valid, action, table_index, key_value, fragment_id,
		class_value, atom_slot, coord_x, coord_y, coord_z, output ready);
endinterface
`default_nettype wire

// ===== sv/cfk_out_if.sv =====
// Result channel of the classifier: valid/ready plus one result's fields.
// Depends on nothing but the language.
`default_nettype none
interface cfk_out_if;
	logic               valid;
	logic               ready;
	logic signed [20:0] fragment_key;
	logic        [9:0]  fragment_number;
	logic        [1:0]  structure_class;
	logic               key_table_empty;
	logic               class_missing;

	modport source(output valid, fragment_key, fragment_number, structure_class,
		key_table_empty, class_missing, input ready);
	modport sink(input valid, fragment_key, fragment_number, structure_class,
		key_table_empty, class_missing, output ready);
endinterface
`default_nettype wire

// ===== sv/cfk_ram.sv =====
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
`default_nettype none
module cfk_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic                 clk,
	input  wire logic                 we,
	input  wire logic [AW-1:0]        waddr,
	input  wire logic [WIDTH-1:0]     wdata,
	input  wire logic [AW-1:0]        raddr,
	output      logic [WIDTH-1:0]     rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule
`default_nettype wire

// ===== sv/cfk_datapath.sv =====
// Datapath: atom registers, shared multiplier, bin search, key search, tables.
// Depends on cfk_pkg, cfk_in_if, cfk_out_if, cfk_ram and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"
module cfk_datapath #(
	parameter int KEY_TABLE_DEPTH = 16384,
	parameter int FRAG_TABLE_DEPTH = 1024,
	parameter int COORD_FRAC_BITS = 8
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire cfk_pkg::cmd_t cmd,
	output      cfk_pkg::sts_t sts,
	cfk_in_if.sink             item,
	cfk_out_if.source          result
);
	import cfk_pkg::*;

	localparam int KA_W  = (KEY_TABLE_DEPTH > 1) ? $clog2(KEY_TABLE_DEPTH) : 1;
	localparam int CNT_W = $clog2(KEY_TABLE_DEPTH + 1);
	localparam int CA_W  = $clog2(FRAG_TABLE_DEPTH);

	// ---------------- atoms ----------------
	logic signed [23:0] atom_q [4][3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int p = 0; p < 4; p++) begin
				for (int k = 0; k < 3; k++) begin
					atom_q[p][k] <= '0;
				end
			end
		end else if (cmd.take && item.action == ACT_ATOM) begin
			atom_q[item.atom_slot][0] <= item.coord_x;
			atom_q[item.atom_slot][1] <= item.coord_y;
			atom_q[item.atom_slot][2] <= item.coord_z;
		end
	end

	// ---------------- shared multiplier ----------------
	op_t                op;
	logic signed [24:0] da, db;
	logic signed [26:0] opa, opb;
	logic signed [26:0] opa_s1, opb_s1;
	logic        [2:0]  kind_s1, kind_s2;
	logic        [1:0]  j_s1, j_s2;
	logic               v_s1, v_s2;
	logic signed [53:0] prod_s2;
	logic        [49:0] s_q [3];
	logic signed [50:0] c_q [3];
	logic signed [76:0] acc_q;
	logic signed [76:0] prod_ext;

	always_comb begin
		op  = mul_op(cmd.mul_step);
		da  = 25'(atom_q[op.ap][op.ak]) - 25'(atom_q[op.aq][op.ak]);
		db  = 25'(atom_q[op.bp][op.bk]) - 25'(atom_q[op.bq][op.bk]);
		opb = 27'(db);
		case (op.kind)
			OP_TH:   opa = c_q[op.ak][50:SPLIT_BITS];
			OP_TL:   opa = $signed({3'b000, c_q[op.ak][SPLIT_BITS-1:0]});
			default: opa = 27'(da);
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= cmd.mul_issue;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		opa_s1  <= opa;
		opb_s1  <= opb;
		kind_s1 <= op.kind;
		j_s1    <= op.j;
		prod_s2 <= opa_s1 * opb_s1;
		kind_s2 <= kind_s1;
		j_s2    <= j_s1;
	end

	assign prod_ext = 77'(prod_s2);

	// Accumulate sums, cross terms and the triple product
	always_ff @(posedge clk) begin
		if (cmd.take) begin
			for (int j = 0; j < 3; j++) begin
				s_q[j] <= '0;
			end
			acc_q <= '0;
		end else if (v_s2) begin
			case (kind_s2)
				OP_SQ:   s_q[j_s2] <= s_q[j_s2] + prod_s2[49:0];
				OP_XP:   c_q[j_s2] <= prod_s2[50:0];
				OP_XN:   c_q[j_s2] <= c_q[j_s2] - prod_s2[50:0];
				OP_TH:   acc_q <= acc_q + (prod_ext <<< SPLIT_BITS);
				OP_TL:   acc_q <= acc_q + prod_ext;
				default: acc_q <= acc_q;
			endcase
		end
	end

	// ---------------- distance bins ----------------
	logic [6:0]  bin_q [3];
	logic [6:0]  cand  [3];
	logic [56:0] lhs   [3];
	logic [56:0] rhs   [3];

	always_comb begin
		for (int j = 0; j < 3; j++) begin
			cand[j] = bin_q[j] | (7'd1 << cmd.bin_bit);
			lhs[j]  = ({7'd0, s_q[j]} << 6) + ({7'd0, s_q[j]} << 5)
				+ ({7'd0, s_q[j]} << 2);
			rhs[j]  = 57'(sq9(cand[j])) << (2 * COORD_FRAC_BITS);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int j = 0; j < 3; j++) begin
				bin_q[j] <= '0;
			end
		end else begin
			for (int j = 0; j < 3; j++) begin
				if (cmd.take) begin
					bin_q[j] <= '0;
				end else if (cmd.bin_step && cand[j] <= 7'(BIN_MAX) && lhs[j] >= rhs[j]) begin
					bin_q[j] <= cand[j];
				end
			end
		end
	end

	// ---------------- key ----------------
	logic        [19:0] mag;
	logic signed [20:0] key_q;

	assign mag = 20'(bin_q[2]) * 20'(KEY_W_HI) + 20'(bin_q[1]) * 20'(KEY_W_MD)
		+ 20'(bin_q[0]);

	always_ff @(posedge clk) begin
		if (cmd.key_load) begin
			key_q <= acc_q[76] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
		end
	end

	// ---------------- key table and search ----------------
	logic [31:0]        idx_ext;
	logic               key_we;
	logic [CNT_W-1:0]   key_count_q, idx_cnt;
	logic [CNT_W-1:0]   lo_q, hi_q, mid, fin;
	logic [KA_W-1:0]    key_raddr;
	logic [30:0]        krd;
	logic signed [20:0] rd_key;

	assign idx_ext = 32'(item.table_index);
	assign key_we  = cmd.take && item.action == ACT_KEY && idx_ext < 32'(KEY_TABLE_DEPTH);
	assign idx_cnt = CNT_W'(idx_ext + 32'd1);
	assign mid     = lo_q + ((hi_q - lo_q) >> 1);
	assign rd_key  = krd[30:10];

	always_comb begin
		if (lo_q < key_count_q) begin
			fin = lo_q;
		end else if (key_q <= 21'sd0) begin
			fin = '0;
		end else begin
			fin = key_count_q - CNT_W'(1);
		end
	end

	assign key_raddr = sts.srch_done ? fin[KA_W-1:0] : mid[KA_W-1:0];

	cfk_ram #(.WIDTH(31), .DEPTH(KEY_TABLE_DEPTH)) u_key_ram (
		.clk   (clk),
		.we    (key_we),
		.waddr (idx_ext[KA_W-1:0]),
		.wdata ({item.key_value, item.fragment_id}),
		.raddr (key_raddr),
		.rdata (krd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_count_q <= '0;
			lo_q        <= '0;
			hi_q        <= '0;
		end else begin
			if (key_we && idx_cnt > key_count_q) begin
				key_count_q <= idx_cnt;
			end
			if (cmd.srch_init) begin
				lo_q <= '0;
				hi_q <= key_count_q;
			end else if (cmd.srch_upd) begin
				if (rd_key < key_q) begin
					lo_q <= mid + CNT_W'(1);
				end else begin
					hi_q <= mid;
				end
			end
		end
	end

	// ---------------- class table ----------------
	logic [9:0]      frag_q;
	logic            empty_q;
	logic [31:0]     fid_ext, frag_ext;
	logic [CA_W-1:0] clr_q;
	logic            cls_we;
	logic [CA_W-1:0] cls_waddr;
	logic [2:0]      cls_wdata, crd;
	logic            miss;

	assign fid_ext  = 32'(item.fragment_id);
	assign frag_ext = 32'(frag_q);

	always_comb begin
		if (cmd.clr_step) begin
			cls_we    = 1'b1;
			cls_waddr = clr_q;
			cls_wdata = '0;
		end else begin
			cls_we    = cmd.take && item.action == ACT_CLASS
				&& fid_ext < 32'(FRAG_TABLE_DEPTH);
			cls_waddr = fid_ext[CA_W-1:0];
			cls_wdata = {1'b1, item.class_value};
		end
	end

	cfk_ram #(.WIDTH(3), .DEPTH(FRAG_TABLE_DEPTH)) u_cls_ram (
		.clk   (clk),
		.we    (cls_we),
		.waddr (cls_waddr),
		.wdata (cls_wdata),
		.raddr (frag_ext[CA_W-1:0]),
		.rdata (crd)
	);

	assign miss = frag_ext >= 32'(FRAG_TABLE_DEPTH) || !crd[2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (cmd.clr_step) begin
			clr_q <= clr_q + CA_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.frag_load) begin
			frag_q  <= (key_count_q == '0) ? 10'd1 : krd[9:0];
			empty_q <= key_count_q == '0;
		end
	end

	// ---------------- result register ----------------
	logic               out_valid_q;
	logic signed [20:0] out_key_q;
	logic        [9:0]  out_frag_q;
	logic        [1:0]  out_cls_q;
	logic               out_empty_q, out_miss_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_key_q   <= key_q;
			out_frag_q  <= frag_q;
			out_cls_q   <= miss ? 2'd0 : crd[1:0];
			out_empty_q <= empty_q;
			out_miss_q  <= miss;
		end
	end

	assign result.valid           = out_valid_q;
	assign result.fragment_key    = out_key_q;
	assign result.fragment_number = out_frag_q;
	assign result.structure_class = out_cls_q;
	assign result.key_table_empty = out_empty_q;
	assign result.class_missing   = out_miss_q;

	assign item.ready = cmd.ready;

	// ---------------- status ----------------
	assign sts.in_valid  = item.valid;
	assign sts.classify  = item.action == ACT_ATOM && item.atom_slot == SLOT_LAST;
	assign sts.clr_last  = clr_q == CA_W'(FRAG_TABLE_DEPTH - 1);
	assign sts.srch_done = !(lo_q < hi_q);
	assign sts.key_empty = key_count_q == '0;
	assign sts.out_full  = out_valid_q && !result.ready;

	`CFK_ASSERT_NOW(a_srch_bounds, 1'b1, lo_q <= hi_q && hi_q <= key_count_q, "search bounds out of order")
	`CFK_ASSERT_NOW(a_bin_sat, 1'b1, bin_q[0] <= 7'(BIN_MAX) && bin_q[1] <= 7'(BIN_MAX) && bin_q[2] <= 7'(BIN_MAX), "bin above saturation")
	`CFK_ASSERT_NEXT(a_out_load, cmd.out_load, out_valid_q, "loaded result not presented")
endmodule
`default_nettype wire

// ===== sv/cfk_ctrl.sv =====
// Controller: sequences clearing, multiplier steps, bins, search and output.
// Depends on cfk_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"
module cfk_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire cfk_pkg::sts_t sts,
	output      cfk_pkg::cmd_t cmd
);
	import cfk_pkg::*;

	localparam logic [3:0] S_CLEAR = 4'd0;
	localparam logic [3:0] S_IDLE  = 4'd1;
	localparam logic [3:0] S_MUL   = 4'd2;
	localparam logic [3:0] S_DRAIN = 4'd3;
	localparam logic [3:0] S_BIN   = 4'd4;
	localparam logic [3:0] S_KEY   = 4'd5;
	localparam logic [3:0] S_SRD   = 4'd6;
	localparam logic [3:0] S_SCMP  = 4'd7;
	localparam logic [3:0] S_FWT   = 4'd8;
	localparam logic [3:0] S_CRD   = 4'd9;
	localparam logic [3:0] S_CWT   = 4'd10;

	logic [3:0] state_q, state_d;
	logic [4:0] step_q, step_d;
	logic [2:0] bit_q, bit_d;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		step_d  = step_q;
		bit_d   = bit_q;
		cmd.mul_step = step_q;
		cmd.bin_bit  = bit_q;
		case (state_q)
			S_CLEAR: begin
				cmd.clr_step = 1'b1;
				if (sts.clr_last) state_d = S_IDLE;
			end
			S_IDLE: begin
				cmd.ready = 1'b1;
				cmd.take  = sts.in_valid;
				if (sts.in_valid && sts.classify) begin
					state_d = S_MUL;
					step_d  = '0;
				end
			end
			S_MUL: begin
				cmd.mul_issue = 1'b1;
				if (step_q == 5'(MUL_STEPS - 1)) begin
					state_d = S_DRAIN;
					bit_d   = '0;
				end else begin
					step_d = step_q + 5'd1;
				end
			end
			S_DRAIN: begin
				// hold until the last product has been accumulated
				if (bit_q == 3'd1) begin
					state_d = S_BIN;
					bit_d   = 3'd6;
				end else begin
					bit_d = bit_q + 3'd1;
				end
			end
			S_BIN: begin
				cmd.bin_step = 1'b1;
				if (bit_q == 3'd0) begin
					state_d = S_KEY;
				end else begin
					bit_d = bit_q - 3'd1;
				end
			end
			S_KEY: begin
				cmd.key_load  = 1'b1;
				cmd.srch_init = 1'b1;
				state_d = sts.key_empty ? S_FWT : S_SRD;
			end
			S_SRD: begin
				state_d = sts.srch_done ? S_FWT : S_SCMP;
			end
			S_SCMP: begin
				cmd.srch_upd = 1'b1;
				state_d = S_SRD;
			end
			S_FWT: begin
				cmd.frag_load = 1'b1;
				state_d = S_CRD;
			end
			S_CRD: begin
				state_d = S_CWT;
			end
			S_CWT: begin
				if (!sts.out_full) begin
					cmd.out_load = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			step_q  <= '0;
			bit_q   <= '0;
		end else begin
			state_q <= state_d;
			step_q  <= step_d;
			bit_q   <= bit_d;
		end
	end

	`CFK_ASSERT_NOW(a_out_room, cmd.out_load, !sts.out_full, "result loaded over a waiting one")
	`CFK_ASSERT_NEXT(a_start, cmd.take && sts.classify, state_q == S_MUL, "classification did not start")
	`CFK_ASSERT_NOW(a_upd_live, cmd.srch_upd, !sts.srch_done, "search step after convergence")
endmodule
`default_nettype wire

// ===== sv/ca_fragment_key_classifier.sv =====
// Top level of the backbone fragment key classifier.
// Depends on cfk_pkg, cfk_in_if, cfk_out_if, cfk_ctrl and cfk_datapath.
//
// Usage:
//  item   : valid/ready input beats. A beat writes a key table slot, writes a
//           class table entry, or stores one atom position. The beat for atom
//           slot 3 starts a classification.
//  result : valid/ready output beats, one per classification, carrying the key,
//           fragment number, class and the two flags.
//  Table writes and atoms 0 to 2 are taken back to back. A classification
//  shows its result after its key search (up to ceil(log2(n+1)) steps over n
//  stored keys; none with an empty table), and item is ready again in the
//  same cycle: the shared 27x27 multiplier runs 21 products and then drains,
//  the three bins resolve in 7 parallel steps, and each search step needs one
//  registered read of the key memory.
//  Reset: after arst_n is released the class table valid flags are cleared,
//  one entry per cycle, for FRAG_TABLE_DEPTH cycles; item is not ready then.
//  The key table starts empty; its entries are undefined until written.
//  A stalled receiver holds the result in the output register; table writes
//  and atoms are still taken, and the next classification waits at its end.
`default_nettype none
module ca_fragment_key_classifier #(
	parameter int KEY_TABLE_DEPTH = 16384,
	parameter int FRAG_TABLE_DEPTH = 1024,
	parameter int COORD_FRAC_BITS = 8
) (
	input wire logic  clk,
	input wire logic  arst_n,
	cfk_in_if.sink    item,
	cfk_out_if.source result
);
	import cfk_pkg::*;

	cmd_t cmd;
	sts_t sts;

	// sequence control
	cfk_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.sts    (sts),
		.cmd    (cmd)
	);

	// arithmetic, tables and the result register
	cfk_datapath #(
		.KEY_TABLE_DEPTH  (KEY_TABLE_DEPTH),
		.FRAG_TABLE_DEPTH (FRAG_TABLE_DEPTH),
		.COORD_FRAC_BITS  (COORD_FRAC_BITS)
	) u_datapath (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.sts    (sts),
		.item   (item),
		.result (result)
	);
endmodule
`default_nettype wire
